>>> sv/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

    // Sample slots carried on every frame, used or not
    localparam int SLOTS = 8;

    // Width of the phase step register, Q.FRAC_BITS
    localparam int STEP_BITS = 20;

    // Register port
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 4;

    // Results one input frame may cause
    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] RESULT_CAP = 5'd16;

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET    = 20'd65536;
    localparam logic [3:0]           CHANNEL_COUNT_RESET = 4'd2;

    typedef enum logic [1:0] {
        REG_PHASE_STEP      = 2'd0,
        REG_CHANNEL_COUNT   = 2'd1,
        REG_OUT_FRAME_COUNT = 2'd2
    } t_reg_idx;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the incoming frame
        logic diff;       // form next minus previous per lane
        logic mul;        // register frac * diff
        logic add;        // register pending result, advance position
        logic push;       // pending result to output register
        logic push_last;  // pushed beat closes this frame's run
        logic finish;     // end of frame: update stream state
        logic hold;       // current frame on both sides, zero fraction
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bypass;
        logic last;
        logic pair_ok;
        logic count_ok;
        logic pend_valid;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: register port and wiring.
//
//  Channel   Beat                        Handshake
//  input     sample_0..7, last_frame     i_in_valid / o_in_stall
//  output    out_0..7, last_of_run,      o_out_valid / i_out_stall
//            stream_done
//  config    APB write / read            psel, penable, pwrite, pready
//
// One frame at a time. A frame is accepted, then each of its k results takes a
// decide, multiply and add step, and a closing decision ends the frame; k is at
// most 16. A stall on the output side lengthens the frame. The single output
// register plus one pending result register hold the results in flight: a result
// waits in pending until the output beat ahead is taken.
// Reset is synchronous and clears stream state and registers to their
// defaults; the block accepts a frame in the cycle after reset lifts.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    parameter int FRAC_BITS    = 16,
    parameter int COUNT_BITS   = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input frames
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_0,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_1,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_2,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_3,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_4,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_5,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_6,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_7,
    input  wire logic                          i_last_frame,
    // output frames
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_out_0,
    output logic signed [SAMPLE_BITS-1:0]      o_out_1,
    output logic signed [SAMPLE_BITS-1:0]      o_out_2,
    output logic signed [SAMPLE_BITS-1:0]      o_out_3,
    output logic signed [SAMPLE_BITS-1:0]      o_out_4,
    output logic signed [SAMPLE_BITS-1:0]      o_out_5,
    output logic signed [SAMPLE_BITS-1:0]      o_out_6,
    output logic signed [SAMPLE_BITS-1:0]      o_out_7,
    output logic                               o_last_of_run,
    output logic                               o_stream_done,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lir_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [lir_pkg::DATA_BITS-1:0] pwdata,
    output logic [lir_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);
    import lir_pkg::*;

    logic [STEP_BITS-1:0]  r_phase_step;
    logic [3:0]            r_channel_count;
    logic [COUNT_BITS-1:0] r_out_frame_count;

    logic                          wr_en;
    logic signed [SAMPLE_BITS-1:0] w_samples [SLOTS];
    logic signed [SAMPLE_BITS-1:0] w_out     [SLOTS];
    t_cmd                          w_cmd;
    t_stat                         w_stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step      <= PHASE_STEP_RESET;
            r_channel_count   <= CHANNEL_COUNT_RESET;
            r_out_frame_count <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PHASE_STEP:      r_phase_step      <= pwdata[STEP_BITS-1:0];
                REG_CHANNEL_COUNT:   r_channel_count   <= pwdata[3:0];
                REG_OUT_FRAME_COUNT: r_out_frame_count <= pwdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PHASE_STEP:      prdata = DATA_BITS'(r_phase_step);
            REG_CHANNEL_COUNT:   prdata = DATA_BITS'(r_channel_count);
            REG_OUT_FRAME_COUNT: prdata = DATA_BITS'(r_out_frame_count);
            default:             prdata = '0;
        endcase
    end

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lir_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_samples         (w_samples),
        .i_last_frame      (i_last_frame),
        .i_phase_step      (r_phase_step),
        .i_channel_count   (r_channel_count),
        .i_out_frame_count (r_out_frame_count),
        .o_out             (w_out),
        .o_out_last        (o_last_of_run),
        .o_out_done        (o_stream_done),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall)
    );

    assign o_out_0 = w_out[0];
    assign o_out_1 = w_out[1];
    assign o_out_2 = w_out[2];
    assign o_out_3 = w_out[3];
    assign o_out_4 = w_out[4];
    assign o_out_5 = w_out[5];
    assign o_out_6 = w_out[6];
    assign o_out_7 = w_out[7];

    // a result is never moved over a beat that has not yet been taken
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !w_stat.out_busy)
        else $error("result pushed over an untaken output beat");

    // a new frame only enters once the previous frame's results are all out of pending
    a_load_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_stat.pend_valid)
        else $error("frame accepted with a result still pending");

    // accepting a frame makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a frame was accepted");

    // the add step always follows a multiply
    a_add_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.add |-> $past(w_cmd.mul))
        else $error("add step without a preceding multiply");

endmodule

`default_nettype wire

>>> sv/lir_ctrl.sv
// Sequencer for the resampler: walks the results of one input frame.
`timescale 1ns / 1ps
`default_nettype none

module lir_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  lir_pkg::t_stat     i_stat,
    output lir_pkg::t_cmd      o_cmd
);
    import lir_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_ADD  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CAP_BITS-1:0] r_count, n_count;
    logic                r_hold, n_hold;

    logic room;
    logic go_byp, go_pair, go_hold, go, wait_out;

    always_comb begin
        room     = r_count < RESULT_CAP;
        go_byp   = i_stat.bypass && (r_count == '0);
        go_pair  = !i_stat.bypass && i_stat.pair_ok && room;
        go_hold  = !i_stat.bypass && !go_pair && i_stat.last && i_stat.count_ok && room;
        go       = go_byp || go_pair || go_hold;
        // a finished result may only move on once the output register is free
        wait_out = i_stat.pend_valid && i_stat.out_busy;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_hold  = r_hold;
        o_cmd   = '0;
        o_cmd.hold = r_hold;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_count    = '0;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.diff = 1'b1;
                if (!wait_out) begin
                    o_cmd.push      = i_stat.pend_valid;
                    o_cmd.push_last = !go;
                    if (go) begin
                        n_hold  = !go_pair;
                        n_count = r_count + 1'b1;
                        n_state = ST_MUL;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_EVAL;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_hold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hold  <= n_hold;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> sv/lir_dpath.sv
// Resampler datapath: stream state, per-lane interpolation, output register.
`timescale 1ns / 1ps
`default_nettype none

module lir_dpath #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    parameter int FRAC_BITS    = 16,
    parameter int COUNT_BITS   = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  lir_pkg::t_cmd                            i_cmd,
    output lir_pkg::t_stat                           o_stat,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_samples [lir_pkg::SLOTS],
    input  wire logic                                i_last_frame,
    input  wire logic [lir_pkg::STEP_BITS-1:0]       i_phase_step,
    input  wire logic [3:0]                          i_channel_count,
    input  wire logic [COUNT_BITS-1:0]               i_out_frame_count,
    output logic signed [SAMPLE_BITS-1:0]            o_out [lir_pkg::SLOTS],
    output logic                                     o_out_last,
    output logic                                     o_out_done,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall
);
    import lir_pkg::*;

    localparam int POS_BITS  = COUNT_BITS + FRAC_BITS;
    localparam int SUM_BITS  = ((POS_BITS > STEP_BITS) ? POS_BITS : STEP_BITS) + 1;
    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic [63:0] UNITY_STEP = 64'd1 << FRAC_BITS;

    // frame and lane registers
    logic signed [SAMPLE_BITS-1:0] r_cur  [SLOTS];
    logic signed [SAMPLE_BITS-1:0] r_prev [SLOTS];
    logic signed [SAMPLE_BITS:0]   r_diff [SLOTS];
    logic signed [PROD_BITS-1:0]   r_prod [SLOTS];
    logic signed [SAMPLE_BITS-1:0] r_pend [SLOTS];
    logic signed [SAMPLE_BITS-1:0] r_out  [SLOTS];
    logic                          r_last;
    logic                          r_pend_valid;
    logic                          r_pend_done;
    logic                          r_out_valid;
    logic                          r_out_last;
    logic                          r_out_done;

    // stream state
    logic                  r_have_prev;
    logic [COUNT_BITS-1:0] r_frames_seen;
    logic [POS_BITS-1:0]   r_pos;
    logic [COUNT_BITS-1:0] r_done_cnt;

    logic                          bypass;
    logic                          count_ok;
    logic [SUM_BITS-1:0]           pos_sum;
    logic [POS_BITS-1:0]           n_pos;
    logic [COUNT_BITS:0]           done_inc;
    logic                          hit_count;
    logic [FRAC_BITS-1:0]          frac_op;
    logic                          lane_en [SLOTS];
    logic signed [SAMPLE_BITS-1:0] lane_a  [SLOTS];
    logic signed [PROD_BITS-1:0]   lane_shr [SLOTS];
    logic [SAMPLE_BITS+1:0]        lane_sum [SLOTS];

    always_comb begin
        bypass    = ({{(64 - STEP_BITS){1'b0}}, i_phase_step} == UNITY_STEP);
        count_ok  = r_done_cnt < i_out_frame_count;
        pos_sum   = SUM_BITS'(r_pos) + SUM_BITS'(i_phase_step);
        n_pos     = (pos_sum > SUM_BITS'({POS_BITS{1'b1}})) ? {POS_BITS{1'b1}}
                                                             : pos_sum[POS_BITS-1:0];
        done_inc  = {1'b0, r_done_cnt} + (COUNT_BITS + 1)'(1);
        hit_count = done_inc == {1'b0, i_out_frame_count};
        frac_op   = i_cmd.hold ? '0 : r_pos[FRAC_BITS-1:0];
        for (int c = 0; c < SLOTS; c++) begin
            lane_en[c]  = (c < MAX_CHANNELS) && (c < int'(i_channel_count));
            lane_a[c]   = i_cmd.hold ? r_cur[c] : r_prev[c];
            lane_shr[c] = r_prod[c] >>> FRAC_BITS;
            lane_sum[c] = {{2{lane_a[c][SAMPLE_BITS-1]}}, lane_a[c]}
                        + lane_shr[c][SAMPLE_BITS+1:0];
        end
    end

    // lane payload
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < SLOTS; c++) begin
            if (!i_rst_n) begin
                r_prev[c] <= '0;
            end else if (i_cmd.finish && !r_last) begin
                r_prev[c] <= r_cur[c];
            end
            if (i_cmd.load) begin
                r_cur[c] <= i_samples[c];
            end
            if (i_cmd.diff) begin
                r_diff[c] <= {r_cur[c][SAMPLE_BITS-1], r_cur[c]}
                           - {r_prev[c][SAMPLE_BITS-1], r_prev[c]};
            end
            if (i_cmd.mul) begin
                r_prod[c] <= r_diff[c] * $signed({1'b0, frac_op});
            end
            if (i_cmd.add) begin
                r_pend[c] <= lane_en[c] ? lane_sum[c][SAMPLE_BITS-1:0] : '0;
            end
            if (i_cmd.push) begin
                r_out[c] <= r_pend[c];
            end
        end
        if (i_cmd.load) begin
            r_last <= i_last_frame;
        end
        if (i_cmd.add) begin
            r_pend_done <= bypass ? r_last : hit_count;
        end
        if (i_cmd.push) begin
            r_out_last <= i_cmd.push_last;
            r_out_done <= r_pend_done;
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_have_prev   <= 1'b0;
            r_frames_seen <= '0;
            r_pos         <= '0;
            r_done_cnt    <= '0;
        end else begin
            if (i_cmd.add) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push) begin
                r_pend_valid <= 1'b0;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.add && !bypass) begin
                r_done_cnt <= done_inc[COUNT_BITS-1:0];
                r_pos      <= n_pos;
            end

            if (i_cmd.finish) begin
                if (r_last) begin
                    r_have_prev   <= 1'b0;
                    r_frames_seen <= '0;
                    r_pos         <= '0;
                    r_done_cnt    <= '0;
                end else begin
                    r_have_prev <= 1'b1;
                    if (r_frames_seen != {COUNT_BITS{1'b1}}) begin
                        r_frames_seen <= r_frames_seen + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_stat.bypass     = bypass;
        o_stat.last       = r_last;
        o_stat.count_ok   = count_ok;
        o_stat.pair_ok    = r_have_prev && count_ok
                          && (r_pos[POS_BITS-1:FRAC_BITS] < r_frames_seen);
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_busy   = r_out_valid;
    end

    assign o_out       = r_out;
    assign o_out_last  = r_out_last;
    assign o_out_done  = r_out_done;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
